@@ rtl/ccs_pkg.sv @@
// Shared types and byte constants for the C comment stripper.
package ccs_pkg;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_DQ    = 8'h22;
    localparam logic [7:0] CHAR_SQ    = 8'h27;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Depth of the result queue; an item adds at most two beats.
    localparam int QUEUE_DEPTH = 3;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic       text_done;
        logic       unclosed_comment;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

@@ rtl/c_comment_stripper.sv @@
// Top level of the C comment stripper: lexer stage feeding the result queue.
//
// Source bytes enter on i_valid/o_ready with i_ch and i_end_of_text; filtered
// beats leave on o_valid/i_ready. Each input beat yields zero, one or two
// result beats; o_last marks the final beat of an item, and an end-of-text
// beat yields exactly one result with o_text_done set, carrying any held
// slash or backslash and o_unclosed_comment if a block comment was open.
// i_cfg_we writes i_cfg_data into the strip flag (reset 1: strip comments);
// write it only while the block is idle.
// An input beat is held in the input register and then in the result queue
// before it reaches o_valid. One byte is taken per cycle while results drain;
// a byte's two beats leave in turn, and the input side follows the three-entry
// result queue: o_ready stays high while the queue holds at most one beat.
// When the receiver stalls, the queue fills and then the input register
// holds its byte, so o_ready drops; no beat is lost or repeated.
// Reset is synchronous and active low: lexer state returns to normal text,
// the queue and input register empty, and the strip flag returns to 1.
module c_comment_stripper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_last,
    output logic       o_text_done,
    output logic       o_unclosed_comment,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    ccs_pkg::t_push   w_push;
    ccs_pkg::t_result w_head;
    logic             w_room;

    ccs_lexer u_lexer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ch          (i_ch),
        .i_end_of_text (i_end_of_text),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_room        (w_room),
        .o_push        (w_push)
    );

    ccs_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (w_head)
    );

    assign o_out_char         = w_head.out_char;
    assign o_char_valid       = w_head.char_valid;
    assign o_last             = w_head.last;
    assign o_text_done        = w_head.text_done;
    assign o_unclosed_comment = w_head.unclosed_comment;

endmodule

@@ rtl/ccs_lexer.sv @@
// Input register, lexer state and result generation for one source byte.
module ccs_lexer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_ch,
    input  logic           i_end_of_text,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    input  logic           i_room,
    output ccs_pkg::t_push o_push
);

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_LITERAL = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_BLOCK   = 3'd3,
        MODE_STAR    = 3'd4
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_quote, n_quote;
    logic       r_hs, n_hs;
    logic       r_hb, n_hb;
    logic       r_strip;
    logic       r_iv;
    logic [7:0] r_ch;
    logic       r_eot;
    logic       w_advance;

    logic [1:0] w_cnt;
    logic [7:0] w_ch0, w_ch1;
    logic       w_plain;
    logic       w_flush_valid;
    logic [7:0] w_flush_char;

    assign w_advance = r_iv && i_room;
    assign o_ready   = !r_iv || i_room;

    always_comb begin
        n_mode        = r_mode;
        n_quote       = r_quote;
        n_hs          = r_hs;
        n_hb          = r_hb;
        w_cnt         = 2'd0;
        w_ch0         = r_ch;
        w_ch1         = r_ch;
        w_plain       = 1'b0;
        w_flush_valid = 1'b0;
        w_flush_char  = 8'h00;
        if (r_eot) begin
            if (r_hs) begin
                w_flush_valid = 1'b1;
                w_flush_char  = ccs_pkg::CHAR_SLASH;
            end else if (r_hb && r_mode != MODE_LITERAL) begin
                w_flush_valid = 1'b1;
                w_flush_char  = ccs_pkg::CHAR_BSL;
            end
            n_mode  = MODE_NORMAL;
            n_quote = 8'h00;
            n_hs    = 1'b0;
            n_hb    = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_LITERAL: begin
                    w_cnt = 2'd1;
                    if (r_hb) begin
                        n_hb = 1'b0;
                    end else if (r_ch == ccs_pkg::CHAR_BSL) begin
                        n_hb = 1'b1;
                    end else if (r_ch == r_quote) begin
                        n_mode  = MODE_NORMAL;
                        n_quote = 8'h00;
                    end
                end
                MODE_LINE: begin
                    if (r_ch == ccs_pkg::CHAR_NL) begin
                        n_mode = MODE_NORMAL;
                        w_cnt  = 2'd1;
                    end else if (!r_strip) begin
                        w_cnt = 2'd1;
                    end
                end
                MODE_BLOCK, MODE_STAR: begin
                    if (r_mode == MODE_STAR && r_ch == ccs_pkg::CHAR_SLASH) begin
                        n_mode = MODE_NORMAL;
                        w_cnt  = 2'd1;
                        w_ch0  = r_strip ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_SLASH;
                    end else begin
                        n_mode = (r_ch == ccs_pkg::CHAR_STAR) ? MODE_STAR : MODE_BLOCK;
                        if (!r_strip) begin
                            w_cnt = 2'd1;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                    if (r_hb) begin
                        n_hb = 1'b0;
                        // A backslash before a newline is a line splice: both vanish.
                        if (r_ch != ccs_pkg::CHAR_NL) begin
                            w_cnt   = 2'd1;
                            w_ch0   = ccs_pkg::CHAR_BSL;
                            w_plain = 1'b1;
                        end
                    end else if (r_hs) begin
                        n_hs = 1'b0;
                        if (r_ch == ccs_pkg::CHAR_SLASH || r_ch == ccs_pkg::CHAR_STAR) begin
                            n_mode = (r_ch == ccs_pkg::CHAR_SLASH) ? MODE_LINE : MODE_BLOCK;
                            if (!r_strip) begin
                                w_cnt = 2'd2;
                                w_ch0 = ccs_pkg::CHAR_SLASH;
                            end
                        end else begin
                            w_cnt   = 2'd1;
                            w_ch0   = ccs_pkg::CHAR_SLASH;
                            w_plain = 1'b1;
                        end
                    end else begin
                        w_plain = 1'b1;
                    end
                    // Plain handling of the byte once any held byte is out.
                    if (w_plain) begin
                        if (r_ch == ccs_pkg::CHAR_BSL) begin
                            n_hb = 1'b1;
                        end else if (r_ch == ccs_pkg::CHAR_SLASH) begin
                            n_hs = 1'b1;
                        end else begin
                            if (r_ch == ccs_pkg::CHAR_DQ || r_ch == ccs_pkg::CHAR_SQ) begin
                                n_quote = r_ch;
                                n_mode  = MODE_LITERAL;
                            end
                            if (w_cnt == 2'd0) begin
                                w_ch0 = r_ch;
                            end
                            w_cnt = w_cnt + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_push = '0;
        if (w_advance) begin
            if (r_eot) begin
                o_push.count                 = 2'd1;
                o_push.res0.out_char         = w_flush_char;
                o_push.res0.char_valid       = w_flush_valid;
                o_push.res0.last             = 1'b1;
                o_push.res0.text_done        = 1'b1;
                o_push.res0.unclosed_comment = (r_mode == MODE_BLOCK || r_mode == MODE_STAR);
            end else begin
                o_push.count           = w_cnt;
                o_push.res0.out_char   = w_ch0;
                o_push.res0.char_valid = 1'b1;
                o_push.res0.last       = (w_cnt == 2'd1);
                o_push.res1.out_char   = w_ch1;
                o_push.res1.char_valid = 1'b1;
                o_push.res1.last       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_quote <= 8'h00;
            r_hs    <= 1'b0;
            r_hb    <= 1'b0;
            r_strip <= 1'b1;
            r_iv    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_strip <= i_cfg_data;
            end
            if (w_advance) begin
                r_mode  <= n_mode;
                r_quote <= n_quote;
                r_hs    <= n_hs;
                r_hb    <= n_hb;
            end
            if (i_valid && o_ready) begin
                r_iv <= 1'b1;
            end else if (w_advance) begin
                r_iv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch  <= i_ch;
            r_eot <= i_end_of_text;
        end
    end

endmodule

@@ rtl/ccs_out_queue.sv @@
// Three-entry result queue that takes up to two beats per item.
module ccs_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ccs_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output ccs_pkg::t_result o_head
);

    ccs_pkg::t_result r_q [ccs_pkg::QUEUE_DEPTH];
    ccs_pkg::t_result n_q [ccs_pkg::QUEUE_DEPTH];
    logic [1:0]       r_cnt;
    logic             w_pop;
    logic [1:0]       w_base;

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];
    assign w_pop   = o_valid && i_ready;
    assign w_base  = r_cnt - {1'b0, w_pop};
    // Room for two more beats even if nothing drains this cycle.
    assign o_room  = (r_cnt <= 2'd1);

    always_comb begin
        for (int k = 0; k < ccs_pkg::QUEUE_DEPTH; k++) begin
            if (w_pop && k < ccs_pkg::QUEUE_DEPTH - 1) begin
                n_q[k] = r_q[k + 1];
            end else begin
                n_q[k] = r_q[k];
            end
            if (i_push.count != 2'd0 && w_base == 2'(k)) begin
                n_q[k] = i_push.res0;
            end
            if (i_push.count == 2'd2 && w_base + 2'd1 == 2'(k)) begin
                n_q[k] = i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= w_base + i_push.count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ccs_pkg::QUEUE_DEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

endmodule
